[src/spp_pkg.sv]
`timescale 1ns / 1ps

package spp_pkg;

    // Store geometry default
    localparam int STORE_DEPTH = 65536;

    // Sample and configuration widths
    localparam int SAMPLE_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd4;

    // Register reset values
    localparam logic [16:0] Q16_ONE      = 17'd65536;
    localparam logic [16:0] BALANCE_RST  = 17'd32768;
    localparam logic [23:0] DELAY_RST    = 24'd6144000;
    localparam logic [15:0] FEEDBACK_RST = 16'd45875;
    localparam logic [16:0] MIX_RST      = 17'd65536;
    localparam logic [15:0] GAIN_RST     = 16'd4096;

    // Input and result items
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } t_out;

    // Per-step strobes from the sequencer to both lanes
    typedef struct packed {
        logic wp;     // weight the input
        logic win;    // round weighted input
        logic lat_a;  // capture first neighbor
        logic ip;     // interpolation product
        logic dly;    // delayed sample
        logic mp;     // mix and feedback products
        logic res;    // mixed result and store data
        logic gp;     // output gain product
        logic pass;   // read position meets write position
        logic va;     // first neighbor holds written data
        logic vb;     // second neighbor holds written data
        logic we;     // store write
    } t_lane_ctl;

    // Number of conditional subtract steps to reduce a 24-bit delay modulo span
    function automatic int red_steps(input longint span);
        int n;
        n = 0;
        for (int k = 0; k < 25; k++) begin
            if ((span << k) <= 64'hFF_FFFF) begin
                n++;
            end
        end
        return n;
    endfunction

    // Saturate to a 24-bit signed sample
    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [31:0] x);
        if (x > 32'sd8388607) begin
            return 24'h7F_FFFF;
        end else if (x < -32'sd8388608) begin
            return 24'h80_0000;
        end
        return x[SAMPLE_W-1:0];
    endfunction

endpackage

[src/spp_ram.sv]
`timescale 1ns / 1ps

module spp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/spp_dly_red.sv]
`timescale 1ns / 1ps

module spp_dly_red #(
    parameter int DEPTH = spp_pkg::STORE_DEPTH,
    localparam int AW = $clog2(DEPTH),
    localparam int SW = AW + 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [spp_pkg::CFG_DATA_W-1:0]    i_value,
    output logic                              o_busy,
    output logic [SW-1:0]                     o_dmod
);

    localparam longint SPAN  = longint'(DEPTH) * 256;
    localparam int     NSTEP = spp_pkg::red_steps(SPAN);
    localparam int     CW    = (NSTEP > 0) ? $clog2(NSTEP + 1) : 1;
    localparam longint DIV0  = (SPAN << NSTEP) >> 1;

    logic [23:0]   r_x;
    logic [23:0]   r_div;
    logic [CW-1:0] r_cnt;

    // Restoring reduction: one conditional subtract of span<<k per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= spp_pkg::DELAY_RST;
            r_div <= 24'(DIV0);
            r_cnt <= CW'(NSTEP);
        end else if (i_load) begin
            r_x   <= i_value;
            r_div <= 24'(DIV0);
            r_cnt <= CW'(NSTEP);
        end else if (r_cnt != '0) begin
            if (r_x >= r_div) begin
                r_x <= r_x - r_div;
            end
            r_div <= r_div >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_dmod = SW'(r_x);

endmodule

[src/spp_lane.sv]
`timescale 1ns / 1ps

module spp_lane #(
    parameter int DEPTH = spp_pkg::STORE_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  spp_pkg::t_lane_ctl          i_ctl,
    input  logic signed [23:0]          i_raw,
    input  logic [16:0]                 i_wgt,
    input  logic [16:0]                 i_wet,
    input  logic [15:0]                 i_fb,
    input  logic [15:0]                 i_gain,
    input  logic [7:0]                  i_frac,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic signed [24:0]          i_d_other,
    output logic signed [24:0]          o_d,
    output logic signed [23:0]          o_out
);

    logic [23:0]        rd_data;
    logic [23:0]        wr_data;
    logic signed [23:0] b_val;
    logic signed [24:0] ab_diff;
    logic signed [41:0] wp_rnd;
    logic signed [33:0] ip_rnd;
    logic signed [25:0] mix_diff;
    logic signed [43:0] mp_rnd;
    logic signed [25:0] mp_q;
    logic signed [41:0] fp_rnd;
    logic signed [25:0] fp_q;
    logic signed [41:0] gp_rnd;
    logic signed [29:0] gp_q;

    logic signed [41:0] r_wp;
    logic signed [24:0] r_win;
    logic signed [23:0] r_a;
    logic signed [33:0] r_ip;
    logic signed [24:0] r_d;
    logic signed [43:0] r_mp;
    logic signed [41:0] r_fp;
    logic signed [24:0] r_res;
    logic signed [23:0] r_wd;
    logic signed [41:0] r_gp;

    // Delay store of this channel
    spp_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we),
        .i_waddr (i_wr_addr),
        .i_wdata (wr_data),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_data)
    );

    // Entries not yet written on the first lap read as zero
    assign b_val    = i_ctl.vb ? $signed(rd_data) : '0;
    assign ab_diff  = 25'(b_val) - 25'(r_a);
    assign wr_data  = i_ctl.pass ? '0 : r_wd;

    // Round half up before each scaling shift
    assign wp_rnd   = r_wp + 42'sd32768;
    assign ip_rnd   = r_ip + 34'sd128;
    assign mix_diff = 26'(r_d) - 26'(r_win);
    assign mp_rnd   = r_mp + 44'sd32768;
    assign mp_q     = $signed(mp_rnd[41:16]);
    assign fp_rnd   = r_fp + 42'sd32768;
    assign fp_q     = $signed(fp_rnd[41:16]);
    assign gp_rnd   = r_gp + 42'sd2048;
    assign gp_q     = $signed(gp_rnd[41:12]);

    // Datapath steps, one per sequencer state
    always_ff @(posedge i_clk) begin
        if (i_ctl.wp) begin
            r_wp <= i_raw * $signed({1'b0, i_wgt});
        end
        if (i_ctl.win) begin
            r_win <= $signed(wp_rnd[40:16]);
        end
        if (i_ctl.lat_a) begin
            r_a <= i_ctl.va ? $signed(rd_data) : '0;
        end
        if (i_ctl.ip) begin
            r_ip <= $signed({1'b0, i_frac}) * ab_diff;
        end
        if (i_ctl.dly) begin
            r_d <= 25'(r_a) + $signed(ip_rnd[32:8]);
        end
        if (i_ctl.mp) begin
            r_mp <= $signed({1'b0, i_wet}) * mix_diff;
            r_fp <= i_d_other * $signed({1'b0, i_fb});
        end
        if (i_ctl.res) begin
            r_res <= i_ctl.pass ? 25'(i_raw) : 25'(26'(r_win) + mp_q);
            r_wd  <= spp_pkg::sat24(32'(27'(r_win) + 27'(fp_q)));
        end
        if (i_ctl.gp) begin
            r_gp <= r_res * $signed({1'b0, i_gain});
        end
    end

    assign o_d   = r_d;
    assign o_out = spp_pkg::sat24(32'(gp_q));

endmodule

[src/stereo_ping_pong_delay.sv]
`timescale 1ns / 1ps

// Stereo ping-pong delay with fractional read position and linear interpolation.
// One stereo item is taken at a time: after acceptance the sequencer runs the
// address, two read, interpolation, delay, mix, sum and gain states, registers
// the result once the output register is free, and only then takes the next.
// This sequence comes from the single read port of each delay store (two
// neighboring entries are fetched one after the other) and the chain of
// registered multiplies for weighting, interpolation, mix, feedback and gain.
// A full output register holds the last step until the result is taken.
// After reset and after each delay_time write the input is held off while the
// delay is reduced modulo the store length, one subtract a cycle (no subtracts
// at the default depth). The stores need no clearing pass: on the first lap
// entries at or beyond the write index read as zero. Configuration writes are
// taken at any cycle, without wait.

module stereo_ping_pong_delay #(
    parameter int STORE_DEPTH = spp_pkg::STORE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  spp_pkg::t_in                       i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output spp_pkg::t_out                      o_out,
    input  logic                               i_cfg_we,
    input  logic [spp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int SW = AW + 8;
    localparam logic [SW:0]   SPAN = (SW + 1)'(longint'(STORE_DEPTH) * 256);
    localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_ADDR = 10'b00_0000_0010,
        S_RD0  = 10'b00_0000_0100,
        S_RD1  = 10'b00_0000_1000,
        S_INT  = 10'b00_0001_0000,
        S_DLY  = 10'b00_0010_0000,
        S_MIX  = 10'b00_0100_0000,
        S_SUM  = 10'b00_1000_0000,
        S_GAIN = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    t_state             r_state, n_state;
    spp_pkg::t_in       r_in;
    spp_pkg::t_out      r_out;
    logic               r_out_valid;
    logic [AW-1:0]      r_w;
    logic               r_wrap;
    logic [AW-1:0]      r_r, r_r1;
    logic [7:0]         r_frac;
    logic               r_pass;
    logic               r_va, r_vb;
    logic [16:0]        r_wgt_l, r_wgt_r, r_wet;
    logic [15:0]        r_fb, r_gain;

    logic               dly_busy;
    logic [SW-1:0]      dmod;
    logic [SW:0]        pos_sum;
    logic [SW-1:0]      pos;
    logic [AW-1:0]      rd_idx, rd_idx1;
    logic [AW-1:0]      rd_addr;
    logic               in_acc;
    logic               out_ld;
    logic [16:0]        bal_sat, mix_sat;
    spp_pkg::t_lane_ctl ctl;
    logic signed [24:0] d_l, d_r;
    logic signed [23:0] y_l, y_r;

    // Delay reduced modulo span
    spp_dly_red #(
        .DEPTH (STORE_DEPTH)
    ) u_dly_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cfg_we && (i_cfg_idx == spp_pkg::CFG_DELAY)),
        .i_value (i_cfg_data),
        .o_busy  (dly_busy),
        .o_dmod  (dmod)
    );

    // Configuration registers, balance and mix saturated to 1.0 on write
    assign bal_sat = (i_cfg_data[16:0] > spp_pkg::Q16_ONE) ? spp_pkg::Q16_ONE
                                                           : i_cfg_data[16:0];
    assign mix_sat = bal_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wgt_l <= spp_pkg::Q16_ONE - spp_pkg::BALANCE_RST;
            r_wgt_r <= spp_pkg::BALANCE_RST;
            r_wet   <= spp_pkg::MIX_RST;
            r_fb    <= spp_pkg::FEEDBACK_RST;
            r_gain  <= spp_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spp_pkg::CFG_BALANCE: begin
                    r_wgt_l <= spp_pkg::Q16_ONE - bal_sat;
                    r_wgt_r <= bal_sat;
                end
                spp_pkg::CFG_FEEDBACK: r_fb   <= i_cfg_data[15:0];
                spp_pkg::CFG_MIX:      r_wet  <= mix_sat;
                spp_pkg::CFG_GAIN:     r_gain <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Handshakes
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && !dly_busy;
    assign out_ld     = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Read position: write index minus delay, modulo span
    assign pos_sum = {1'b0, r_w, 8'h00} + SPAN - {1'b0, dmod};
    assign pos     = (pos_sum >= SPAN) ? SW'(pos_sum - SPAN) : SW'(pos_sum);
    assign rd_idx  = pos[SW-1:8];
    assign rd_idx1 = (rd_idx == LAST) ? '0 : rd_idx + 1'b1;
    assign rd_addr = (r_state == S_RD1) ? r_r1 : r_r;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_ADDR;
            S_ADDR:  n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_INT;
            S_INT:   n_state = S_DLY;
            S_DLY:   n_state = S_MIX;
            S_MIX:   n_state = S_SUM;
            S_SUM:   n_state = S_GAIN;
            S_GAIN:  n_state = S_OUT;
            S_OUT:   if (out_ld) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_w         <= '0;
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_ld) begin
                r_w <= (r_w == LAST) ? '0 : r_w + 1'b1;
                if (r_w == LAST) begin
                    r_wrap <= 1'b1;
                end
            end
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and per-item address state
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
        if (r_state == S_ADDR) begin
            r_r    <= rd_idx;
            r_r1   <= rd_idx1;
            r_frac <= pos[7:0];
            r_pass <= (rd_idx == r_w);
        end
        if (r_state == S_RD0) begin
            r_va <= r_wrap || (r_r < r_w);
            r_vb <= r_wrap || (r_r1 < r_w);
        end
        if (out_ld) begin
            r_out.out_left  <= y_l;
            r_out.out_right <= y_r;
        end
    end

    // Lane strobes
    always_comb begin
        ctl       = '0;
        ctl.wp    = (r_state == S_ADDR);
        ctl.win   = (r_state == S_RD0);
        ctl.lat_a = (r_state == S_RD1);
        ctl.ip    = (r_state == S_INT);
        ctl.dly   = (r_state == S_DLY);
        ctl.mp    = (r_state == S_MIX);
        ctl.res   = (r_state == S_SUM);
        ctl.gp    = (r_state == S_GAIN);
        ctl.pass  = r_pass;
        ctl.va    = r_va;
        ctl.vb    = r_vb;
        // first lap always writes so that every entry below the index is defined
        ctl.we    = (r_state == S_GAIN) && (!r_pass || !r_wrap);
    end

    // Two channel lanes, cross-coupled through the delayed samples
    spp_lane #(
        .DEPTH (STORE_DEPTH)
    ) u_lane_l (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_raw     (r_in.in_left),
        .i_wgt     (r_wgt_l),
        .i_wet     (r_wet),
        .i_fb      (r_fb),
        .i_gain    (r_gain),
        .i_frac    (r_frac),
        .i_rd_addr (rd_addr),
        .i_wr_addr (r_w),
        .i_d_other (d_r),
        .o_d       (d_l),
        .o_out     (y_l)
    );

    spp_lane #(
        .DEPTH (STORE_DEPTH)
    ) u_lane_r (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_raw     (r_in.in_right),
        .i_wgt     (r_wgt_r),
        .i_wet     (r_wet),
        .i_fb      (r_fb),
        .i_gain    (r_gain),
        .i_frac    (r_frac),
        .i_rd_addr (rd_addr),
        .i_wr_addr (r_w),
        .i_d_other (d_l),
        .o_d       (d_r),
        .o_out     (y_r)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_ADDR))
        else $error("accepted item did not start the sequence");

    a_index_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_ld |=> (r_w == $past(r_w)))
        else $error("write index moved without a result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("finished step left while output was blocked");

    a_wrap_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_wrap))
        else $error("first-lap flag cleared outside reset");

endmodule

[tb/stereo_ping_pong_delay_tb.sv]
`timescale 1ns / 1ps

// Tracks the expected stereo output of the delay line and checks each result item
class pingpong_scoreboard;
    logic [16:0] balance;
    logic [23:0] delay_fx;
    logic [15:0] fb_gain;
    logic [16:0] wet_share;
    logic [15:0] out_gain;

    int left_mem[];
    int right_mem[];
    int wr_pos;

    spp_pkg::t_out pending_pairs[$];
    int failures;
    int checked;

    function new();
        balance   = spp_pkg::BALANCE_RST;
        delay_fx  = spp_pkg::DELAY_RST;
        fb_gain   = spp_pkg::FEEDBACK_RST;
        wet_share = spp_pkg::MIX_RST;
        out_gain  = spp_pkg::GAIN_RST;
        left_mem  = new[spp_pkg::STORE_DEPTH];
        right_mem = new[spp_pkg::STORE_DEPTH];
        wr_pos    = 0;
        failures  = 0;
        checked   = 0;
    endfunction

    // Round to nearest, halves toward +inf
    function longint rnd(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function int clip24(longint x);
        if (x > 8388607) begin
            return 8388607;
        end else if (x < -8388608) begin
            return -8388608;
        end
        return int'(x);
    endfunction

    // Register write; indexes past the list are dropped
    function void write_reg(logic [spp_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
        case (idx)
            spp_pkg::CFG_BALANCE:  balance   = data[16:0];
            spp_pkg::CFG_DELAY:    delay_fx  = data;
            spp_pkg::CFG_FEEDBACK: fb_gain   = data[15:0];
            spp_pkg::CFG_MIX:      wet_share = data[16:0];
            spp_pkg::CFG_GAIN:     out_gain  = data[15:0];
            default: ;
        endcase
    endfunction

    // Predict the output pair for an accepted input item and update the stores
    function void note_pair(spp_pkg::t_in it);
        longint span, pos, raw_l, raw_r, bal, wet, w_l, w_r;
        longint a_l, b_l, a_r, b_r, d_l, d_r, res_l, res_r;
        int rd, rd1, frac;
        spp_pkg::t_out want;

        span  = longint'(spp_pkg::STORE_DEPTH) * 256;
        raw_l = $signed(it.in_left);
        raw_r = $signed(it.in_right);
        pos   = (longint'(wr_pos) * 256 + span - (longint'(delay_fx) % span)) % span;
        rd    = int'(pos >>> 8);
        frac  = int'(pos % 256);

        if (rd == wr_pos) begin
            // read meets write: raw inputs, nothing stored
            res_l = raw_l;
            res_r = raw_r;
        end else begin
            bal = (balance > spp_pkg::Q16_ONE) ? longint'(spp_pkg::Q16_ONE) : longint'(balance);
            wet = (wet_share > spp_pkg::Q16_ONE) ? longint'(spp_pkg::Q16_ONE)
                                                 : longint'(wet_share);
            w_l = rnd(raw_l * (longint'(spp_pkg::Q16_ONE) - bal), 16);
            w_r = rnd(raw_r * bal, 16);
            rd1 = (rd + 1) % spp_pkg::STORE_DEPTH;
            a_l = left_mem[rd];
            b_l = left_mem[rd1];
            a_r = right_mem[rd];
            b_r = right_mem[rd1];
            d_l = a_l + rnd(longint'(frac) * (b_l - a_l), 8);
            d_r = a_r + rnd(longint'(frac) * (b_r - a_r), 8);
            res_l = w_l + rnd(wet * (d_l - w_l), 16);
            res_r = w_r + rnd(wet * (d_r - w_r), 16);
            // cross-coupled feedback
            left_mem[wr_pos]  = clip24(w_l + rnd(d_r * longint'(fb_gain), 16));
            right_mem[wr_pos] = clip24(w_r + rnd(d_l * longint'(fb_gain), 16));
        end

        want.out_left  = 24'(clip24(rnd(res_l * longint'(out_gain), 12)));
        want.out_right = 24'(clip24(rnd(res_r * longint'(out_gain), 12)));
        pending_pairs.push_back(want);
        wr_pos = (wr_pos + 1) % spp_pkg::STORE_DEPTH;
    endfunction

    function void check_pair(spp_pkg::t_out got);
        spp_pkg::t_out want;
        if (pending_pairs.size() == 0) begin
            failures++;
            if (failures <= 10) begin
                $display("unexpected item out: L=%0d R=%0d",
                         $signed(got.out_left), $signed(got.out_right));
            end
            return;
        end
        want = pending_pairs.pop_front();
        if (got.out_left !== want.out_left || got.out_right !== want.out_right) begin
            failures++;
            if (failures <= 10) begin
                $display("item %0d mismatch: expected L=%0d R=%0d, got L=%0d R=%0d", checked,
                         $signed(want.out_left), $signed(want.out_right),
                         $signed(got.out_left), $signed(got.out_right));
            end
        end
        checked++;
    endfunction
endclass

module stereo_ping_pong_delay_tb;
    import spp_pkg::*;

    localparam int DEPTH       = spp_pkg::STORE_DEPTH;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [23:0] S_MAX = 24'h7F_FFFF;
    localparam logic [23:0] S_MIN = 24'h80_0000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pingpong_scoreboard sb;
    bit hold_req = 1'b0;
    bit calm     = 1'b0;
    int cycle_count = 0;

    stereo_ping_pong_delay #(
        .STORE_DEPTH(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_pair(o_out);
        end
    end

    // Output side: random stall bursts, one long hold on request, none when calm
    initial begin : sink
        int burst;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                burst = $urandom_range(1, 16);
                repeat (burst) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                burst = calm ? 1 : $urandom_range(1, 16);
                repeat (burst) @(posedge i_clk);
            end
        end
    end

    function automatic t_in pair(logic [23:0] l, logic [23:0] r);
        t_in it;
        it.in_left  = l;
        it.in_right = r;
        return it;
    endfunction

    function automatic logic [23:0] rand_sample();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'(S_MAX);
            1: v = 32'(S_MIN);
            2: v = $urandom_range(0, 511) - 256;
            default: v = $urandom;
        endcase
        return v[23:0];
    endfunction

    // Q1.16 pick, including values above 1.0
    function automatic logic [23:0] pick_q16();
        logic [31:0] v;
        case ($urandom_range(0, 6))
            0: v = 0;
            1: v = 32'(Q16_ONE);
            2: v = 32'h1_FFFF;
            3: v = $urandom & 32'h1_FFFF;
            default: v = $urandom_range(0, 65536);
        endcase
        return v[23:0];
    endfunction

    // Sometimes set the unused upper data bits
    function automatic logic [23:0] cfg_word(logic [23:0] value, int width);
        logic [31:0] junk;
        junk = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            return value | (junk[23:0] << width);
        end
        return value;
    endfunction

    // Offer one item and hold it until taken
    task automatic push(t_in it);
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_pair(it);
    endtask

    task automatic pause(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop offering and wait until every expected item is out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_pairs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic configure(logic [23:0] bal, logic [23:0] dly, logic [23:0] fb,
                             logic [23:0] mx, logic [23:0] gn);
        drain();
        set_reg(CFG_BALANCE, bal);
        set_reg(CFG_DELAY, dly);
        set_reg(CFG_FEEDBACK, fb);
        set_reg(CFG_MIX, mx);
        set_reg(CFG_GAIN, gn);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_setup();
        logic [31:0] v;
        logic [23:0] dly, fb, gn;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: dly = '0;
            1: dly = 24'hFF_FFFF;
            2: dly = 24'($urandom_range(1, 255));
            3: dly = v[23:0];
            4: dly = 24'($urandom_range(1, 64) * 256);
            default: dly = 24'($urandom_range(256, 40 * 256));
        endcase
        v = $urandom;
        case ($urandom_range(0, 5))
            0: fb = '0;
            1: fb = 24'h00_FFFF;
            2: fb = {8'h00, v[15:0]};
            default: fb = 24'($urandom_range(0, 58982));
        endcase
        v = $urandom;
        case ($urandom_range(0, 5))
            0: gn = '0;
            1: gn = 24'h00_FFFF;
            2: gn = {8'h00, v[15:0]};
            default: gn = 24'($urandom_range(0, 8192));
        endcase
        configure(cfg_word(pick_q16(), 17), dly, cfg_word(fb, 16),
                  cfg_word(pick_q16(), 17), cfg_word(gn, 16));
    endtask

    // Random items in runs, with random sender gaps between runs
    task automatic stream(int count);
        int run_left;
        run_left = 0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(1, 40);
                if ($urandom_range(0, 1) == 1) begin
                    pause($urandom_range(1, 16));
                end
            end
            run_left--;
            push(pair(rand_sample(), rand_sample()));
        end
    endtask

    initial begin : stimulus
        int lap_items;
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_BALANCE;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, long delay reads unwritten entries as zero
        push(pair(S_MAX, S_MIN));
        push(pair(S_MIN, S_MAX));
        push(pair('0, '0));

        // Zero delay: read meets write, raw pass-through
        configure('0, '0, 24'(FEEDBACK_RST), 24'(Q16_ONE), 24'(GAIN_RST));
        push(pair(S_MAX, S_MIN));
        push(pair(S_MIN, 24'h00_0001));
        // writes to indexes past the list must change nothing
        drain();
        for (int k = CFG_GAIN + 1; k < (1 << CFG_IDX_W); k++) begin
            set_reg(CFG_IDX_W'(k), 24'hFF_FFFF);
        end
        i_cfg_we <= 1'b0;
        push(pair(24'h12_3456, 24'hED_CBA9));

        // Maximum gain saturates the outputs
        configure('0, '0, 24'(FEEDBACK_RST), 24'(Q16_ONE), 24'h00_FFFF);
        push(pair(S_MAX, S_MIN));
        push(pair(24'h00_0100, 24'hFF_FF00));

        // 1.5 sample delay, feedback above 0.9, balance above 1.0
        configure(24'h01_FFFF, 24'd384, 24'h00_FFFF, 24'd32768, 24'(GAIN_RST));
        for (int k = 0; k < 8; k++) begin
            push(pair(k[0] ? S_MAX : S_MIN, k[0] ? S_MIN : S_MAX));
        end

        // Largest delay wraps back onto the write index; mix above 1.0
        configure(24'(Q16_ONE), 24'hFF_FFFF, '0, 24'h01_FFFF, 24'd8191);
        push(pair(S_MAX, S_MIN));
        push(pair(24'h40_0000, 24'hC0_0000));

        // Fraction-only delay interpolates toward the current entry
        configure('0, 24'd255, 24'd58982, 24'(Q16_ONE), 24'(GAIN_RST));
        push(pair(S_MAX, S_MAX));
        push(pair(S_MIN, S_MIN));
        push(pair(24'h00_0001, 24'hFF_FFFF));

        // Random settings and items
        for (int ph = 0; ph < 8; ph++) begin
            random_setup();
            if (ph == 2) begin
                // output held off while items keep coming
                hold_req = 1'b1;
            end
            if (ph == 4) begin
                stream(120);
                drain();
                stream(130);
            end else begin
                stream(250);
            end
        end

        // Last part: no idling; a delay near the store length reads untouched entries
        calm = 1'b1;
        configure(pick_q16(), 24'(24'd65000 * 256 + $urandom_range(0, 255)), 24'd58982,
                  24'd32768, 24'(GAIN_RST));
        lap_items = 200;
        for (int n = 0; n < lap_items; n++) begin
            push(pair(rand_sample(), rand_sample()));
        end

        i_in_valid <= 1'b0;
        while (sb.pending_pairs.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending_pairs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
